// ----- hdl/mbpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker package
// Shared widths, mode and register codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package mbpt_pkg;

  // Field widths of the channels and the configuration port.
  localparam int AMOUNT_W  = 48;
  localparam int MODE_W    = 3;
  localparam int ELAPSED_W = 48;
  localparam int BAR_W     = 32;
  localparam int BEAT_W    = 4;
  localparam int PHASE_W   = 16;
  localparam int PERIOD_W  = 32;
  localparam int BPB_W     = 5;
  localparam int BPP_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Shared divider: 48-bit dividend, 32-bit divisor, one quotient bit a cycle.
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Defaults of the top-level parameters.
  localparam int TIME_BITS_DEF       = 48;
  localparam int BEAT_COUNT_BITS_DEF = 32;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd24000;
  localparam logic [BPB_W-1:0]    BPB_RST    = 5'd4;
  localparam logic [BPP_W-1:0]    BPP_RST    = 7'd8;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_POS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NUDGE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESET   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BARS_PER_PHRASE = 2'd2;

  // Division jobs run on the shared divider.
  typedef enum logic [1:0] {
    OP_POS   = 2'd0,  // position / period: beats and accumulator
    OP_BAR   = 2'd1,  // total beats / beats per bar
    OP_PHASE = 2'd2,  // accumulator * 2^16 / period
    OP_PHR   = 2'd3   // bar / bars per phrase
  } div_op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic    capture;
    logic    div_start;
    div_op_e div_op;
    logic    load_out;
  } mbpt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic derive;
    logic div_done;
  } mbpt_status_t;

endpackage

// ----- hdl/mbpt_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker request channel
// Valid/ready channel that carries one transport request.
// ----------------------------------------------------------------------------
interface mbpt_req_if
  import mbpt_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [AMOUNT_W-1:0] amount;

  modport source (output valid, output mode, output amount, input ready);
  modport sink   (input valid, input mode, input amount, output ready);
endinterface

// ----- hdl/mbpt_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker result channel
// Valid/ready channel that carries one transport position report.
// ----------------------------------------------------------------------------
interface mbpt_res_if
  import mbpt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_ticks;
  logic [BAR_W-1:0]     bar_number;
  logic [BEAT_W-1:0]    beat_in_bar;
  logic [BAR_W-1:0]     phrase_number;
  logic [PHASE_W-1:0]   beat_phase;
  logic                 is_running;
  logic                 on_downbeat;
  logic                 on_phrase_boundary;

  modport source (
    output valid, output elapsed_ticks, output bar_number, output beat_in_bar,
    output phrase_number, output beat_phase, output is_running, output on_downbeat,
    output on_phrase_boundary, input ready
  );
  modport sink (
    input valid, input elapsed_ticks, input bar_number, input beat_in_bar,
    input phrase_number, input beat_phase, input is_running, input on_downbeat,
    input on_phrase_boundary, output ready
  );
endinterface

// ----- hdl/musical_beat_position_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Musical beat position tracker
// Follows a sample-tick transport and reports elapsed time, bar, beat in bar,
// phrase, Q0.16 beat phase, running flag and downbeat/phrase-boundary flags.
//
// Usage: requests (mode, amount) enter on req_i; one report per request
// leaves on res_o. Both are valid/ready channels. Write the registers on
// the cfg_* port only while the block is idle; the block does not enforce
// it. Indexes 0, 1, 2 hold beat period, beats per bar and bars per phrase.
// Sequencing: an advance while running or a set position runs four jobs on
// one shared divider that retires one quotient bit per cycle. Other requests
// run a single bar-modulo job. One request is in work at a time, so the next
// one can be taken in the cycle after the report is loaded.
// Reset: position state clears, the transport is stopped and the registers
// return to 24000, 4 and 8.
// Stall: the report waits in an output register; the next request is taken
// meanwhile and finishes its work, then holds until that register empties.
// ----------------------------------------------------------------------------
module musical_beat_position_tracker_unit
  import mbpt_pkg::*;
#(
  parameter int TIME_BITS       = TIME_BITS_DEF,
  parameter int BEAT_COUNT_BITS = BEAT_COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mbpt_req_if.sink              req_i,
  mbpt_res_if.source            res_o
);

  mbpt_cmd_t    cmd;
  mbpt_status_t status;

  // Request sequencing.
  mbpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Transport state and arithmetic.
  mbpt_dp #(
    .TIME_BITS       (TIME_BITS),
    .BEAT_COUNT_BITS (BEAT_COUNT_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .mode_i               (req_i.mode),
    .amount_i             (req_i.amount),
    .cmd_i                (cmd),
    .status_o             (status),
    .elapsed_ticks_o      (res_o.elapsed_ticks),
    .bar_number_o         (res_o.bar_number),
    .beat_in_bar_o        (res_o.beat_in_bar),
    .phrase_number_o      (res_o.phrase_number),
    .beat_phase_o         (res_o.beat_phase),
    .is_running_o         (res_o.is_running),
    .on_downbeat_o        (res_o.on_downbeat),
    .on_phrase_boundary_o (res_o.on_phrase_boundary)
  );

endmodule

// ----- hdl/mbpt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbpt_div
  import mbpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_W-1:0]    dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic [DIV_W-1:0]    quot_o,
  output logic [PERIOD_W-1:0] rem_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [PERIOD_W-1:0]  dvs_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic [PERIOD_W:0]    shifted;
  logic                 qbit;
  logic [PERIOD_W-1:0]  rem_d;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, dvd_q[DIV_W-1]};
    qbit    = (shifted >= {1'b0, dvs_q});
    if (qbit) begin
      rem_d = PERIOD_W'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = shifted[PERIOD_W-1:0];
    end
  end

  // Control: step count and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands; the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/mbpt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker datapath
// Transport state, configuration registers, shared divider and result register.
// ----------------------------------------------------------------------------
module mbpt_dp
  import mbpt_pkg::*;
#(
  parameter int TIME_BITS       = TIME_BITS_DEF,
  parameter int BEAT_COUNT_BITS = BEAT_COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [MODE_W-1:0]          mode_i,
  input  logic signed [AMOUNT_W-1:0] amount_i,
  input  mbpt_cmd_t                  cmd_i,
  output mbpt_status_t               status_o,
  output logic [ELAPSED_W-1:0]       elapsed_ticks_o,
  output logic [BAR_W-1:0]           bar_number_o,
  output logic [BEAT_W-1:0]          beat_in_bar_o,
  output logic [BAR_W-1:0]           phrase_number_o,
  output logic [PHASE_W-1:0]         beat_phase_o,
  output logic                       is_running_o,
  output logic                       on_downbeat_o,
  output logic                       on_phrase_boundary_o
);

  // Extended width for saturating elapsed-time arithmetic.
  localparam int EW = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;
  localparam logic [EW-1:0] TMAX_EXT = (EW'(1) << TIME_BITS) - EW'(1);

  // Configuration registers.
  logic [PERIOD_W-1:0] beat_period_q;
  logic [BPB_W-1:0]    beats_per_bar_q;
  logic [BPP_W-1:0]    bars_per_phrase_q;

  // Transport state.
  logic [TIME_BITS-1:0]       elapsed_q;
  logic [PERIOD_W-1:0]        acc_q;
  logic [BEAT_COUNT_BITS-1:0] total_q;
  logic                       running_q;
  logic [BEAT_W-1:0]          beat_q;
  logic [BAR_W-1:0]           bar_q;
  logic [BAR_W-1:0]           phrase_q;
  logic [PHASE_W-1:0]         phase_q;

  // Per-request working state.
  logic             derive_q;
  logic             is_set_q;
  logic [DIV_W-1:0] src_q;
  div_op_e          op_q;
  logic             bnd_q;

  // Result register.
  logic [ELAPSED_W-1:0] res_elapsed_q;
  logic [BAR_W-1:0]     res_bar_q;
  logic [BEAT_W-1:0]    res_beat_q;
  logic [BAR_W-1:0]     res_phrase_q;
  logic [PHASE_W-1:0]   res_phase_q;
  logic                 res_running_q;
  logic                 res_down_q;
  logic                 res_bnd_q;

  logic [PERIOD_W-1:0] eff_p;
  logic [BPB_W-1:0]    eff_bpb;
  logic [BPP_W-1:0]    eff_bpp;
  logic                neg;
  logic [AMOUNT_W-1:0] pos;
  logic [AMOUNT_W-1:0] mag;
  logic [EW-1:0]       elap_ext;
  logic [EW-1:0]       add_sum;
  logic [EW-1:0]       add_sat;
  logic [EW-1:0]       sub_sat;
  logic [EW-1:0]       set_val;
  logic [DIV_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [PERIOD_W-1:0] div_rem;
  logic [PERIOD_W+3:0] acc_x10;
  logic                down;

  // Register values as used: zero period acts as one, counts are clamped.
  always_comb begin
    eff_p = (beat_period_q == '0) ? PERIOD_W'(1) : beat_period_q;
    if (beats_per_bar_q == '0) begin
      eff_bpb = BPB_W'(1);
    end else if (beats_per_bar_q > BPB_W'(16)) begin
      eff_bpb = BPB_W'(16);
    end else begin
      eff_bpb = beats_per_bar_q;
    end
    if (bars_per_phrase_q == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (bars_per_phrase_q > BPP_W'(64)) begin
      eff_bpp = BPP_W'(64);
    end else begin
      eff_bpp = bars_per_phrase_q;
    end
  end

  // Amount as a clipped position and as a magnitude.
  assign neg = amount_i[AMOUNT_W-1];
  assign pos = neg ? '0 : AMOUNT_W'(amount_i);
  assign mag = neg ? AMOUNT_W'(-amount_i) : AMOUNT_W'(amount_i);

  // Saturating elapsed-time updates.
  always_comb begin
    elap_ext = EW'(elapsed_q);
    add_sum  = elap_ext + EW'(pos);
    add_sat  = (add_sum > TMAX_EXT) ? TMAX_EXT : add_sum;
    sub_sat  = (elap_ext > EW'(mag)) ? (elap_ext - EW'(mag)) : '0;
    set_val  = (EW'(pos) > TMAX_EXT) ? TMAX_EXT : EW'(pos);
  end

  // Divider operand selection by job.
  always_comb begin
    unique case (cmd_i.div_op)
      OP_POS: begin
        div_dividend = src_q;
        div_divisor  = eff_p;
      end
      OP_BAR: begin
        div_dividend = DIV_W'(total_q);
        div_divisor  = PERIOD_W'(eff_bpb);
      end
      OP_PHASE: begin
        div_dividend = DIV_W'({acc_q, {PHASE_W{1'b0}}});
        div_divisor  = eff_p;
      end
      OP_PHR: begin
        div_dividend = DIV_W'(bar_q);
        div_divisor  = PERIOD_W'(eff_bpp);
      end
      default: begin
        div_dividend = src_q;
        div_divisor  = eff_p;
      end
    endcase
  end

  mbpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Downbeat: first beat of the bar and within the first tenth of the beat.
  assign acc_x10 = ((PERIOD_W + 4)'(acc_q) << 3) + ((PERIOD_W + 4)'(acc_q) << 1);
  assign down    = (beat_q == '0) && (acc_x10 < (PERIOD_W + 4)'(eff_p));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_period_q     <= PERIOD_RST;
      beats_per_bar_q   <= BPB_RST;
      bars_per_phrase_q <= BPP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BEAT_PERIOD:     beat_period_q     <= cfg_data_i[PERIOD_W-1:0];
        CFG_BEATS_PER_BAR:   beats_per_bar_q   <= cfg_data_i[BPB_W-1:0];
        CFG_BARS_PER_PHRASE: bars_per_phrase_q <= cfg_data_i[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Transport state: immediate updates at capture, derived values per divider job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      acc_q     <= '0;
      total_q   <= '0;
      running_q <= 1'b0;
      beat_q    <= '0;
      bar_q     <= '0;
      phrase_q  <= '0;
      phase_q   <= '0;
      bnd_q     <= 1'b0;
    end else if (cmd_i.capture) begin
      unique case (mode_i)
        MODE_ADVANCE: begin
          if (running_q) begin
            elapsed_q <= TIME_BITS'(add_sat);
          end
        end
        MODE_SET_POS: elapsed_q <= TIME_BITS'(set_val);
        MODE_NUDGE:   elapsed_q <= neg ? TIME_BITS'(sub_sat) : TIME_BITS'(add_sat);
        MODE_RESET: begin
          elapsed_q <= '0;
          acc_q     <= '0;
          total_q   <= '0;
          beat_q    <= '0;
          bar_q     <= '0;
          phrase_q  <= '0;
          phase_q   <= '0;
        end
        MODE_START: running_q <= 1'b1;
        MODE_STOP:  running_q <= 1'b0;
        default: ;
      endcase
    end else if (div_done) begin
      unique case (op_q)
        OP_POS: begin
          total_q <= (is_set_q ? '0 : total_q) + div_quot[BEAT_COUNT_BITS-1:0];
          acc_q   <= div_rem;
        end
        OP_BAR: begin
          bar_q  <= div_quot[BAR_W-1:0];
          beat_q <= div_rem[BEAT_W-1:0];
        end
        OP_PHASE: phase_q <= div_quot[PHASE_W-1:0];
        OP_PHR: begin
          if (derive_q) begin
            phrase_q <= div_quot[BAR_W-1:0];
          end
          bnd_q <= (div_rem == '0);
        end
        default: ;
      endcase
    end
  end

  // Working state of the request under way.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      derive_q <= 1'b0;
      is_set_q <= 1'b0;
      op_q     <= OP_POS;
    end else begin
      if (cmd_i.capture) begin
        derive_q <= ((mode_i == MODE_ADVANCE) && running_q) || (mode_i == MODE_SET_POS);
        is_set_q <= (mode_i == MODE_SET_POS);
      end
      if (cmd_i.div_start) begin
        op_q <= cmd_i.div_op;
      end
    end
  end

  // Dividend of the position job: new position, or accumulator plus advance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      src_q <= (mode_i == MODE_SET_POS) ? DIV_W'(pos) : (DIV_W'(acc_q) + DIV_W'(pos));
    end
  end

  // Result register, loaded once the request is fully worked out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_elapsed_q <= elap_ext[ELAPSED_W-1:0];
      res_bar_q     <= bar_q;
      res_beat_q    <= beat_q;
      res_phrase_q  <= phrase_q;
      res_phase_q   <= phase_q;
      res_running_q <= running_q;
      res_down_q    <= down;
      res_bnd_q     <= down && bnd_q;
    end
  end

  assign status_o.derive   = derive_q;
  assign status_o.div_done = div_done;

  assign elapsed_ticks_o      = res_elapsed_q;
  assign bar_number_o         = res_bar_q;
  assign beat_in_bar_o        = res_beat_q;
  assign phrase_number_o      = res_phrase_q;
  assign beat_phase_o         = res_phase_q;
  assign is_running_o         = res_running_q;
  assign on_downbeat_o        = res_down_q;
  assign on_phrase_boundary_o = res_bnd_q;

endmodule

// ----- hdl/mbpt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker controller
// Sequences the divider jobs of one request and hands off the result.
// ----------------------------------------------------------------------------
module mbpt_ctrl
  import mbpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  mbpt_status_t status_i,
  output mbpt_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_POS  = 6'b000010,
    ST_BAR  = 6'b000100,
    ST_PHS  = 6'b001000,
    ST_PHR  = 6'b010000,
    ST_PUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands. Each job state starts the divider once and waits
  // for its completion pulse; without a derive, ST_POS goes straight to ST_PHR.
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_POS;
        end
      end
      ST_POS: begin
        cmd_o.div_op = OP_POS;
        if (!status_i.derive) begin
          state_d = ST_PHR;
        end else if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (status_i.div_done) begin
          issued_d = 1'b0;
          state_d  = ST_BAR;
        end
      end
      ST_BAR: begin
        cmd_o.div_op = OP_BAR;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (status_i.div_done) begin
          issued_d = 1'b0;
          state_d  = ST_PHS;
        end
      end
      ST_PHS: begin
        cmd_o.div_op = OP_PHASE;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (status_i.div_done) begin
          issued_d = 1'b0;
          state_d  = ST_PHR;
        end
      end
      ST_PHR: begin
        cmd_o.div_op = OP_PHR;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (status_i.div_done) begin
          issued_d = 1'b0;
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d  = ST_IDLE;
        issued_d = 1'b0;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- verif/mbpt_position_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker scoreboard
// Watches the request, report and register ports of the tracker, keeps its
// own copy of the transport state and registers, predicts one position
// report per accepted request and compares every accepted report with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mbpt_position_checker
  import mbpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mbpt_req_if                   req_mon,
  mbpt_res_if                   res_mon,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    checked_o
);

  // Largest elapsed time for the default time width.
  localparam logic [63:0] TICKS_MAX = (64'd1 << ELAPSED_W) - 64'd1;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [BAR_W-1:0]     bar;
    logic [BEAT_W-1:0]    beat;
    logic [BAR_W-1:0]     phrase;
    logic [PHASE_W-1:0]   phase;
    logic                 running;
    logic                 downbeat;
    logic                 phrase_edge;
  } position_t;

  // Register copies.
  logic [PERIOD_W-1:0] period_q;
  logic [BPB_W-1:0]    bpb_q;
  logic [BPP_W-1:0]    bpp_q;

  // Transport state copies.
  logic [63:0]        elapsed_q;
  logic [63:0]        acc_q;
  logic [31:0]        beats_q;
  logic               running_q;
  logic [BEAT_W-1:0]  beat_q;
  logic [BAR_W-1:0]   bar_q;
  logic [BAR_W-1:0]   phrase_q;
  logic [PHASE_W-1:0] phase_q;

  position_t reports_q[$];
  int        mismatch_cnt;
  int        issued_n;
  int        retired_n;

  assign mismatches_o  = mismatch_cnt;
  assign outstanding_o = issued_n - retired_n;
  assign checked_o     = retired_n;

  // Effective register values: a zero period acts as one, the bar and
  // phrase lengths are clamped into their legal ranges.
  function automatic logic [63:0] beat_len();
    return (period_q == '0) ? 64'd1 : {32'd0, period_q};
  endfunction

  function automatic logic [63:0] bar_len();
    if (bpb_q == '0) return 64'd1;
    return (bpb_q > 5'd16) ? 64'd16 : {59'd0, bpb_q};
  endfunction

  function automatic logic [63:0] phrase_len();
    if (bpp_q == '0) return 64'd1;
    return (bpp_q > 7'd64) ? 64'd64 : {57'd0, bpp_q};
  endfunction

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TICKS_MAX) ? TICKS_MAX : s;
  endfunction

  // Rebuild beat, bar, phrase and phase from the beat count and accumulator.
  task automatic refresh_position();
    logic [63:0] q;
    q = {32'd0, beats_q} % bar_len();
    beat_q = q[BEAT_W-1:0];
    q = {32'd0, beats_q} / bar_len();
    bar_q = q[BAR_W-1:0];
    q = {32'd0, bar_q} / phrase_len();
    phrase_q = q[BAR_W-1:0];
    q = (acc_q << 16) / beat_len();
    phase_q = q[PHASE_W-1:0];
  endtask

  // Apply one request to the state copy and build the report it yields.
  task automatic apply_request(input logic [MODE_W-1:0] mode,
                               input logic [AMOUNT_W-1:0] amt,
                               output position_t rep);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] ticks;
    logic [63:0] sum;
    logic [63:0] q;
    logic        down;
    neg   = amt[AMOUNT_W-1];
    mag   = neg ? {16'd0, (~amt + 48'd1)} : {16'd0, amt};
    ticks = neg ? 64'd0 : {16'd0, amt};
    case (mode)
      MODE_ADVANCE: begin
        if (running_q) begin
          elapsed_q = add_clamped(elapsed_q, ticks);
          sum = acc_q + ticks;
          q = sum / beat_len();
          beats_q = beats_q + q[31:0];
          acc_q = sum % beat_len();
          refresh_position();
        end
      end
      MODE_SET_POS: begin
        elapsed_q = (ticks > TICKS_MAX) ? TICKS_MAX : ticks;
        q = ticks / beat_len();
        beats_q = q[31:0];
        acc_q = ticks % beat_len();
        refresh_position();
      end
      MODE_NUDGE: begin
        if (neg) elapsed_q = (elapsed_q > mag) ? elapsed_q - mag : 64'd0;
        else elapsed_q = add_clamped(elapsed_q, mag);
      end
      MODE_RESET: begin
        elapsed_q = '0;
        acc_q     = '0;
        beats_q   = '0;
        beat_q    = '0;
        bar_q     = '0;
        phrase_q  = '0;
        phase_q   = '0;
      end
      MODE_START: running_q = 1'b1;
      MODE_STOP:  running_q = 1'b0;
      default: ;
    endcase

    // Flags always use the registers as they stand now.
    down = (beat_q == '0) && (acc_q * 64'd10 < beat_len());
    rep.elapsed     = elapsed_q[ELAPSED_W-1:0];
    rep.bar         = bar_q;
    rep.beat        = beat_q;
    rep.phrase      = phrase_q;
    rep.phase       = phase_q;
    rep.running     = running_q;
    rep.downbeat    = down;
    rep.phrase_edge = down && (({32'd0, bar_q} % phrase_len()) == 64'd0);
  endtask

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endtask

  // Track register writes, retire reports, then queue the next prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    position_t rep;
    if (!rst_ni) begin
      period_q  = PERIOD_RST;
      bpb_q     = BPB_RST;
      bpp_q     = BPP_RST;
      elapsed_q = '0;
      acc_q     = '0;
      beats_q   = '0;
      running_q = 1'b0;
      beat_q    = '0;
      bar_q     = '0;
      phrase_q  = '0;
      phase_q   = '0;
      reports_q.delete();
      mismatch_cnt = 0;
      issued_n  <= 0;
      retired_n <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BEAT_PERIOD:     period_q = cfg_data_i[PERIOD_W-1:0];
          CFG_BEATS_PER_BAR:   bpb_q    = cfg_data_i[BPB_W-1:0];
          CFG_BARS_PER_PHRASE: bpp_q    = cfg_data_i[BPP_W-1:0];
          default: ;
        endcase
      end

      if (res_mon.valid && res_mon.ready) begin
        if (reports_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t ns: report with none expected, expected nothing, actual elapsed 0x%0h",
                   $time, res_mon.elapsed_ticks);
        end else begin
          rep = reports_q.pop_front();
          retired_n <= retired_n + 1;
          compare_field("elapsed_ticks", 64'(rep.elapsed), 64'(res_mon.elapsed_ticks));
          compare_field("bar_number", 64'(rep.bar), 64'(res_mon.bar_number));
          compare_field("beat_in_bar", 64'(rep.beat), 64'(res_mon.beat_in_bar));
          compare_field("phrase_number", 64'(rep.phrase), 64'(res_mon.phrase_number));
          compare_field("beat_phase", 64'(rep.phase), 64'(res_mon.beat_phase));
          compare_field("is_running", 64'(rep.running), 64'(res_mon.is_running));
          compare_field("on_downbeat", 64'(rep.downbeat), 64'(res_mon.on_downbeat));
          compare_field("on_phrase_boundary", 64'(rep.phrase_edge),
                        64'(res_mon.on_phrase_boundary));
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        apply_request(req_mon.mode, req_mon.amount, rep);
        reports_q.push_back(rep);
        issued_n <= issued_n + 1;
      end
    end
  end

endmodule

// ----- verif/tb_musical_beat_position_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Beat position tracker testbench
// Drives transport requests into the tracker: a directed opening over the
// special cases, then random phases under several register settings with
// random idle and stall bursts. The scoreboard beside the block predicts and
// checks every report; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_musical_beat_position_tracker_unit;
  import mbpt_pkg::*;

  // Codes the block ignores.
  localparam logic [MODE_W-1:0]    MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_SPARE_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  localparam int PHASE_ITEMS    = 210;
  localparam int SETTLE_CYCLES  = 220;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;

  // Idle and stall odds in percent, changed per phase.
  int gap_pct  = 0;
  int hold_pct = 0;

  // Effective register values, used to shape amounts.
  logic [63:0] shape_per = 64'd24000;
  int          shape_bpb = 4;
  int          shape_bpp = 8;
  logic        live = 1'b0;

  int mode_hits[8];
  int settings_n = 1;
  int quiet_cycles = 0;

  mbpt_req_if req_ch ();
  mbpt_res_if res_ch ();

  musical_beat_position_tracker_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  mbpt_position_checker scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .req_mon       (req_ch),
    .res_mon       (res_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always #2 clk = ~clk;

  function automatic logic [47:0] wide_random();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Offer one request, maybe after an idle burst, and wait for acceptance.
  task automatic push_req(input logic [MODE_W-1:0] m, input logic [AMOUNT_W-1:0] a);
    if ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid  <= 1'b0;
      req_ch.mode   <= 3'($urandom_range(0, 7));
      req_ch.amount <= wide_random();
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.mode   <= m;
    req_ch.amount <= a;
    do @(posedge clk); while (!req_ch.ready);
    mode_hits[m]++;
  endtask

  // Let every report drain, then give the block time to go idle.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers and the unused index back to back.
  task automatic program_regs(input logic [31:0] per, input logic [4:0] bpb,
                              input logic [6:0] bpp);
    logic [31:0] word;
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BEAT_PERIOD;
    cfg_data <= per;
    @(posedge clk);
    word = $urandom;
    word[BPB_W-1:0] = bpb;
    cfg_idx  <= CFG_BEATS_PER_BAR;
    cfg_data <= word;
    @(posedge clk);
    word = $urandom;
    word[BPP_W-1:0] = bpp;
    cfg_idx  <= CFG_BARS_PER_PHRASE;
    cfg_data <= word;
    @(posedge clk);
    cfg_idx  <= CFG_SPARE;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    shape_per = (per == '0) ? 64'd1 : {32'd0, per};
    shape_bpb = (bpb == '0) ? 1 : (bpb > 5'd16) ? 16 : int'(bpb);
    shape_bpp = (bpp == '0) ? 1 : (bpp > 7'd64) ? 64 : int'(bpp);
    settings_n++;
  endtask

  // One phase of random requests under one register setting. Most requests
  // are advances sized around the beat period so that beat and bar edges,
  // downbeats and phrase boundaries come up often.
  task automatic run_phase(input logic [31:0] per, input logic [4:0] bpb,
                           input logic [6:0] bpp, input int gap, input int hold);
    int                roll;
    int                kind;
    logic [63:0]       amt;
    logic [63:0]       span;
    logic [MODE_W-1:0] m;
    program_regs(per, bpb, bpp);
    gap_pct  = gap;
    hold_pct = hold;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      kind = $urandom_range(0, 99);
      if (!live && $urandom_range(0, 2) == 0) roll = 80;
      span = shape_per / 16;
      amt  = '0;
      if (roll < 58) begin
        m = MODE_ADVANCE;
        if (kind < 40) begin
          amt = shape_per / 4;
          amt = $urandom_range(0, amt[31:0]);
        end else if (kind < 70) begin
          amt = shape_per * $urandom_range(0, 2 * shape_bpb) + $urandom_range(0, span[31:0]);
        end else if (kind < 85) begin
          amt = shape_per * $urandom_range(1, 3) - $urandom_range(0, span[31:0]);
        end else if (kind < 95) begin
          amt = {24'd0, 40'(wide_random())};
        end else begin
          amt = {16'd0, wide_random()};
        end
      end else if (roll < 68) begin
        m = MODE_SET_POS;
        if (kind < 50) begin
          amt = shape_per * shape_bpb * $urandom_range(0, 2 * shape_bpp)
              + shape_per * $urandom_range(0, shape_bpb) + $urandom_range(0, span[31:0]);
        end else if (kind < 80) begin
          amt = {28'd0, 36'(wide_random())};
        end else begin
          amt = {16'd0, wide_random()};
        end
      end else if (roll < 78) begin
        m = MODE_NUDGE;
        if (kind < 50) amt = $urandom_range(0, 100000);
        else if (kind < 80) amt = {24'd0, 40'(wide_random())};
        else amt = {16'd0, wide_random()};
        if ($urandom_range(0, 1) == 1) amt = -amt;
      end else if (roll < 87) begin
        m = MODE_START;
        amt = {16'd0, wide_random()};
      end else if (roll < 91) begin
        m = MODE_STOP;
        amt = {16'd0, wide_random()};
      end else if (roll < 94) begin
        m = MODE_RESET;
        amt = {16'd0, wide_random()};
      end else if (roll < 96) begin
        m = ($urandom_range(0, 1) == 1) ? MODE_SPARE_A : MODE_SPARE_B;
        amt = {16'd0, wide_random()};
      end else begin
        m = MODE_ADVANCE;
        amt = {16'd0, wide_random()};
      end
      if (m == MODE_START) live = 1'b1;
      if (m == MODE_STOP) live = 1'b0;
      push_req(m, amt[AMOUNT_W-1:0]);
    end
    settle();
  endtask

  // Report side: ready drops in short random bursts.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < hold_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any accepted request or report.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
      $display("musical_beat_position_tracker_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_BEAT_PERIOD;
    cfg_data      <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.mode   <= MODE_ADVANCE;
    req_ch.amount <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset register values.
    gap_pct  = 15;
    hold_pct = 15;
    push_req(MODE_ADVANCE, 48'd1000);                 // stopped: nothing moves
    push_req(MODE_NUDGE, 48'd5000);
    push_req(MODE_NUDGE, 48'h8000_0000_0000);         // most negative: floor at zero
    push_req(MODE_SET_POS, 48'h7FFF_FFFF_FFFF);       // largest position
    push_req(MODE_NUDGE, 48'h7FFF_FFFF_FFFF);
    push_req(MODE_NUDGE, 48'h7FFF_FFFF_FFFF);         // elapsed saturates
    push_req(MODE_START, 48'd0);
    push_req(MODE_ADVANCE, 48'd100);                  // stays saturated
    push_req(MODE_RESET, 48'hFFFF_FFFF_FFFF);
    push_req(MODE_ADVANCE, 48'd0);
    push_req(MODE_ADVANCE, 48'd96000);                // onto the next bar
    push_req(MODE_ADVANCE, 48'd2400);                 // just off the downbeat window
    push_req(MODE_ADVANCE, 48'd1);
    push_req(MODE_ADVANCE, -48'sd5);                  // negative taken as zero
    push_req(MODE_SET_POS, 48'd768000);               // first phrase boundary
    push_req(MODE_SET_POS, -48'sd1);                  // negative position is zero
    push_req(MODE_ADVANCE, 48'd23999);
    push_req(MODE_SPARE_A, wide_random());
    push_req(MODE_SPARE_B, wide_random());
    push_req(MODE_STOP, 48'd0);
    push_req(MODE_ADVANCE, 48'd24000);
    push_req(MODE_SET_POS, 48'd48000);                // set position while stopped
    push_req(MODE_START, 48'd0);
    push_req(MODE_ADVANCE, 48'h7FFF_FFFF_FFFF);       // beat count wraps
    push_req(MODE_NUDGE, -48'sd1000);
    live = 1'b1;
    settle();

    // Random phases, extremes first; the last one runs without idling.
    run_phase(32'd1, 5'd1, 7'd1, 20, 20);
    run_phase(32'hFFFF_FFFF, 5'd16, 7'd64, 0, 25);
    run_phase(32'd0, 5'd0, 7'd0, 25, 0);
    run_phase(32'd7, 5'd31, 7'd127, 0, 0);
    run_phase(32'd24000, 5'd3, 7'd5, 25, 25);
    run_phase(32'($urandom_range(2, 100000)), 5'd17, 7'd65, 10, 30);
    run_phase(32'($urandom_range(1, 2000)), 5'($urandom_range(0, 31)),
              7'($urandom_range(0, 127)), 30, 10);
    run_phase(32'd48000, 5'd4, 7'd8, 0, 0);

    $display("Covered %0d advance, %0d set position, %0d nudge, %0d reset, %0d start/stop",
             mode_hits[MODE_ADVANCE], mode_hits[MODE_SET_POS], mode_hits[MODE_NUDGE],
             mode_hits[MODE_RESET], mode_hits[MODE_START] + mode_hits[MODE_STOP]);
    $display("and %0d unused-mode requests; %0d reports checked over %0d register settings.",
             mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B], checked, settings_n);
    if (mismatches == 0 && outstanding == 0) begin
      $display("musical_beat_position_tracker_unit regression: pass");
    end else begin
      $display("musical_beat_position_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mbpt_pkg.sv
hdl/mbpt_req_if.sv
hdl/mbpt_res_if.sv
hdl/mbpt_div.sv
hdl/mbpt_dp.sv
hdl/mbpt_ctrl.sv
hdl/musical_beat_position_tracker_unit.sv
verif/mbpt_position_checker.sv
verif/tb_musical_beat_position_tracker_unit.sv
